// ----- rtl/fwrm_pkg.sv -----
// ----------------------------------------------------------------------------
// fwrm_pkg: shared types and constants for the running-max fifo
// Payload structs, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package fwrm_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t    operation;
    value_t value;
  } in_item_t;

  typedef struct packed {
    value_t  dequeued_value;
    value_t  current_max;
    logic    max_valid;
    status_t status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_CHK,
    S_ENQ_CMP,
    S_APPEND,
    S_DEQ_CMP,
    S_MAX_RD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/fifo_with_running_max.sv -----
// ----------------------------------------------------------------------------
// fifo_with_running_max: bounded fifo reporting the maximum of its contents
// Value fifo plus a monotonic candidate queue, both in memories, walked by a
// small sequencer that compares each value against the candidate queue.
// ----------------------------------------------------------------------------
//  channel   ports                      payload      direction
//  in        in_valid / in_ready        in_item_t    input
//  out       out_valid / out_ready      out_item_t   output
//
//  one item at a time; in_ready is high only while the sequencer is idle
//  full enq or empty deq: max read, done; dequeue: compare, max read, done
//  enqueue: check, then per candidate popped a compare and a new check, then
//  append, max read and done; check goes straight to append when the candidate
//  list is or runs empty (one read, one compare per pop)
//  a held result in the output register stalls only the final step
//  rst_n empties both queues; memory contents are left as they are
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_running_max #(
  parameter int QUEUE_DEPTH = fwrm_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  fwrm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output fwrm_pkg::out_item_t out_data
);

  import fwrm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  state_t           state_r, state_nxt;
  value_t           val_r, val_nxt;
  status_t          status_r, status_nxt;
  value_t           deq_r, deq_nxt;
  logic [PTR_W-1:0] ent_head_r, ent_head_nxt;
  logic [PTR_W-1:0] ent_tail_r, ent_tail_nxt;
  logic [CNT_W-1:0] ent_count_r, ent_count_nxt;
  logic [PTR_W-1:0] cand_head_r, cand_head_nxt;
  logic [PTR_W-1:0] cand_tail_r, cand_tail_nxt;
  logic [CNT_W-1:0] cand_count_r, cand_count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  value_t           ent_mem [QUEUE_DEPTH];
  value_t           cand_mem [QUEUE_DEPTH];
  value_t           ent_rdata_r;
  value_t           cand_rdata_r;
  logic             ent_we;
  logic             cand_we;
  logic [PTR_W-1:0] cand_raddr;
  logic             in_xfer;
  logic             max_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign max_ok    = (ent_count_r != '0) && (cand_count_r != '0);

  // memories
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_tail_r] <= in_data.value;
    end
    ent_rdata_r <= ent_mem[ent_head_r];
  end

  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_mem[cand_tail_r] <= val_r;
    end
    cand_rdata_r <= cand_mem[cand_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ent_head_r   <= '0;
      ent_tail_r   <= '0;
      ent_count_r  <= '0;
      cand_head_r  <= '0;
      cand_tail_r  <= '0;
      cand_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ent_head_r   <= ent_head_nxt;
      ent_tail_r   <= ent_tail_nxt;
      ent_count_r  <= ent_count_nxt;
      cand_head_r  <= cand_head_nxt;
      cand_tail_r  <= cand_tail_nxt;
      cand_count_r <= cand_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    deq_r      <= deq_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    deq_nxt        = deq_r;
    ent_head_nxt   = ent_head_r;
    ent_tail_nxt   = ent_tail_r;
    ent_count_nxt  = ent_count_r;
    cand_head_nxt  = cand_head_r;
    cand_tail_nxt  = cand_tail_r;
    cand_count_nxt = cand_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ent_we         = 1'b0;
    cand_we        = 1'b0;
    cand_raddr     = cand_head_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          val_nxt    = in_data.value;
          deq_nxt    = '0;
          status_nxt = ST_OK;
          if (in_data.operation == OP_ENQ) begin
            if (ent_count_r == CNT_FULL) begin
              status_nxt = ST_FULL;
              state_nxt  = S_MAX_RD;
            end else begin
              ent_we        = 1'b1;
              ent_tail_nxt  = ptr_next(ent_tail_r);
              ent_count_nxt = ent_count_r + 1'b1;
              state_nxt     = S_ENQ_CHK;
            end
          end else if (ent_count_r == '0) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_MAX_RD;
          end else begin
            state_nxt = S_DEQ_CMP;
          end
        end
      end
      S_ENQ_CHK: begin
        if (cand_count_r == '0) begin
          state_nxt = S_APPEND;
        end else begin
          cand_raddr = ptr_prev(cand_tail_r);
          state_nxt  = S_ENQ_CMP;
        end
      end
      S_ENQ_CMP: begin
        // signed compare against the newest candidate
        if (cand_rdata_r < val_r) begin
          cand_tail_nxt  = ptr_prev(cand_tail_r);
          cand_count_nxt = cand_count_r - 1'b1;
          state_nxt      = S_ENQ_CHK;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        if (cand_count_r != CNT_FULL) begin
          cand_we        = 1'b1;
          cand_tail_nxt  = ptr_next(cand_tail_r);
          cand_count_nxt = cand_count_r + 1'b1;
        end
        state_nxt = S_MAX_RD;
      end
      S_DEQ_CMP: begin
        deq_nxt       = ent_rdata_r;
        ent_head_nxt  = ptr_next(ent_head_r);
        ent_count_nxt = ent_count_r - 1'b1;
        if ((cand_count_r != '0) && (cand_rdata_r == ent_rdata_r)) begin
          cand_head_nxt  = ptr_next(cand_head_r);
          cand_count_nxt = cand_count_r - 1'b1;
        end
        state_nxt = S_MAX_RD;
      end
      S_MAX_RD: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.dequeued_value = deq_r;
          out_data_nxt.current_max    = max_ok ? cand_rdata_r : '0;
          out_data_nxt.max_valid      = max_ok;
          out_data_nxt.status         = status_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_cand_le_ent: assert property (@(posedge clk) disable iff (!rst_n)
    cand_count_r <= ent_count_r)
    else $error("candidate count above entry count");

  a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_count_r <= CNT_FULL)
    else $error("entry count above depth");

  a_idle_has_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (ent_count_r != '0) |-> (cand_count_r != '0))
    else $error("non-empty fifo with no candidate");

  a_max_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.max_valid |-> (out_data_r.current_max == '0))
    else $error("max reported without valid flag");

endmodule

`default_nettype wire

// ----- tb/sv/tb_fifo_with_running_max.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_with_running_max: self-checking bench for the running-max fifo
// A driver feeds queued operations at the falling edge and a monitor checks
// each result transfer against a local fifo plus monotonic candidate queue.
// Both sides idle at random, with a quiet stretch and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_fifo_with_running_max;

  import fwrm_pkg::*;

  localparam int QDEPTH      = DEFAULT_QUEUE_DEPTH;
  localparam int N_RANDOM    = 1800;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 60;

  typedef enum int {
    GEN_RANDOM,
    GEN_TIES,
    GEN_RISING,
    GEN_FALLING,
    GEN_EXTREME
  } gen_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  op_q[$];
  out_item_t max_report_q[$];

  value_t      fifo_mem[QDEPTH];
  int          fifo_rd, fifo_wr, fifo_cnt;
  value_t      cand_mem[QDEPTH];
  int          cand_rd, cand_wr, cand_cnt;

  int unsigned in_count    = 0;
  int unsigned total_ops   = 0;
  int unsigned errors      = 0;
  int unsigned stall_cycles = 0;
  logic        in_taken    = 1'b0;
  int unsigned hold_left   = 0;
  logic        long_hold_done = 1'b0;
  logic        quiet;

  assign quiet = (in_count >= 700) && (in_count < 1000);

  always #10 clk = ~clk;

  fifo_with_running_max #(.QUEUE_DEPTH(QDEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  function automatic out_item_t run_fifo_op(in_item_t it);
    out_item_t r;
    int        back;
    r = '0;
    r.status = ST_OK;
    if (it.operation == OP_ENQ) begin
      if (fifo_cnt >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        fifo_mem[fifo_wr] = it.value;
        fifo_wr = (fifo_wr + 1) % QDEPTH;
        fifo_cnt++;
        // pop smaller candidates from the back, ties stay
        while (cand_cnt > 0) begin
          back = (cand_wr + QDEPTH - 1) % QDEPTH;
          if (!(cand_mem[back] < it.value)) break;
          cand_wr = back;
          cand_cnt--;
        end
        if (cand_cnt < QDEPTH) begin
          cand_mem[cand_wr] = it.value;
          cand_wr = (cand_wr + 1) % QDEPTH;
          cand_cnt++;
        end
      end
    end else begin
      if (fifo_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.dequeued_value = fifo_mem[fifo_rd];
        fifo_rd = (fifo_rd + 1) % QDEPTH;
        fifo_cnt--;
        if (cand_cnt > 0 && cand_mem[cand_rd] == r.dequeued_value) begin
          cand_rd = (cand_rd + 1) % QDEPTH;
          cand_cnt--;
        end
      end
    end
    if (fifo_cnt > 0 && cand_cnt > 0) begin
      r.current_max = cand_mem[cand_rd];
      r.max_valid   = 1'b1;
    end
    return r;
  endfunction

  task automatic queue_op(op_t op, value_t v);
    in_item_t it;
    it.operation = op;
    it.value     = v;
    op_q.push_back(it);
    total_ops++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (op_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 18)) begin
        in_data  <= op_q[0];
        op_q.delete(0);
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the input backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && in_count >= 300) begin
      out_ready      <= 1'b0;
      hold_left      <= 299;
      long_hold_done <= 1'b1;
    end else if (!quiet && $urandom_range(0, 299) == 0) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(20, 120);
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 18);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        max_report_q.push_back(run_fifo_op(in_data));
        in_count <= in_count + 1;
      end
      if (out_valid && out_ready) begin
        if (max_report_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("unexpected result transfer: deq=%0d max=%0d valid=%0b st=%0d",
                     out_data.dequeued_value, out_data.current_max,
                     out_data.max_valid, out_data.status);
        end else begin
          automatic out_item_t want = max_report_q[0];
          max_report_q.delete(0);
          if (out_data.dequeued_value !== want.dequeued_value ||
              out_data.current_max !== want.current_max ||
              out_data.max_valid !== want.max_valid ||
              out_data.status !== want.status) begin
            errors <= errors + 1;
            if (errors < 10)
              $display({"mismatch: expected deq=%0d max=%0d valid=%0b st=%0d, ",
                        "got deq=%0d max=%0d valid=%0b st=%0d"},
                       want.dequeued_value, want.current_max, want.max_valid,
                       want.status, out_data.dequeued_value, out_data.current_max,
                       out_data.max_valid, out_data.status);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL fifo_with_running_max");
    $finish;
  end

  initial begin
    int        enq_pct;
    int        burst;
    int        step;
    value_t    base;
    value_t    v;
    gen_mode_t mode;
    int        n_random;

    fifo_rd  = 0;
    fifo_wr  = 0;
    fifo_cnt = 0;
    cand_rd  = 0;
    cand_wr  = 0;
    cand_cnt = 0;
    foreach (fifo_mem[i]) fifo_mem[i] = '0;
    foreach (cand_mem[i]) cand_mem[i] = '0;

    // dequeue on empty, extremes, tie on the maximum
    queue_op(OP_DEQ, 32'sh5a5a5a5a);
    queue_op(OP_ENQ, 32'sh7fffffff);
    queue_op(OP_ENQ, 32'sh80000000);
    queue_op(OP_ENQ, 32'sh7fffffff);
    queue_op(OP_DEQ, '1);
    queue_op(OP_DEQ, '0);
    queue_op(OP_DEQ, '0);
    queue_op(OP_DEQ, '0);
    // fill to full with a falling then rising run, then overflow
    for (int i = 0; i < QDEPTH; i++)
      queue_op(OP_ENQ, (i < QDEPTH / 2) ? value_t'(-i) : value_t'(i * 1000 - 32'sd20000));
    queue_op(OP_ENQ, 32'sh7fffffff);
    queue_op(OP_ENQ, 32'sh80000000);

    n_random = 0;
    while (n_random < N_RANDOM) begin
      case ($urandom_range(0, 4))
        0: enq_pct = 10;
        1: enq_pct = 35;
        2: enq_pct = 50;
        3: enq_pct = 65;
        default: enq_pct = 90;
      endcase
      burst = $urandom_range(10, 60);
      mode  = gen_mode_t'($urandom_range(0, 4));
      base  = $urandom;
      step  = $urandom_range(1, 1000);
      for (int k = 0; k < burst; k++) begin
        case (mode)
          GEN_TIES:    v = value_t'(int'($urandom_range(0, 6)) - 3);
          GEN_RISING:  v = value_t'(base + k * step);
          GEN_FALLING: v = value_t'(base - k * step);
          GEN_EXTREME: begin
            case ($urandom_range(0, 4))
              0: v = 32'sh7fffffff;
              1: v = 32'sh80000000;
              2: v = '0;
              3: v = '1;
              default: v = $urandom;
            endcase
          end
          default:     v = $urandom;
        endcase
        if ($urandom_range(0, 99) < enq_pct)
          queue_op(OP_ENQ, v);
        else
          queue_op(OP_DEQ, $urandom);
        n_random++;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (in_count < total_ops) @(negedge clk);
    while (max_report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (errors == 0 && max_report_q.size() == 0) begin
      $display("PASS fifo_with_running_max");
    end else begin
      $display("FAIL fifo_with_running_max");
    end
    $finish;
  end

endmodule
